### rtl/core/tpe_pkg.sv
package tpe_pkg;

    localparam logic signed [31:0] START_Z = 32'sd13107;

    localparam logic [31:0] GAIN_RESET = 32'd558015;
    localparam logic [15:0] PRINT_FEED_RESET = 16'd1200;
    localparam logic [15:0] TRAVEL_FEED_RESET = 16'd3000;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINT_FEED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_FEED = 2'd2;

    localparam int RAD_W = 66;
    localparam int ROOT_W = 33;
    localparam int REM_W = 36;
    localparam logic [47:0] EXT_MAX = '1;

    typedef struct packed {
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] feed;
        logic        extrude;
    } move_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_MUL,
        B_ACC,
        B_OUT
    } back_state_t;

    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (33'd0 - v) : v;
        return n[31:0];
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/tpe_front.sv
module tpe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [31:0]        s_coord_x,
    input  logic [31:0]        s_coord_y,
    input  logic [31:0]        s_coord_z,
    input  logic               s_keep_z,
    input  logic               s_extrude,
    input  logic [15:0]        print_feed,
    input  logic [15:0]        travel_feed,
    input  logic               q_full,
    output logic               q_push,
    output tpe_pkg::move_t     q_data
);

    logic [31:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic [32:0] cx, cy, cz, ix, iy, iz;
    tpe_pkg::move_t mv;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign q_data  = mv;

    always_comb begin
        cx = {cur_x_reg[31], cur_x_reg};
        cy = {cur_y_reg[31], cur_y_reg};
        cz = {cur_z_reg[31], cur_z_reg};
        ix = {s_coord_x[31], s_coord_x};
        iy = {s_coord_y[31], s_coord_y};
        iz = {s_coord_z[31], s_coord_z};
        mv = '0;
        mv.feed = s_extrude ? print_feed : travel_feed;
        mv.extrude = s_extrude;
        if (s_action) begin
            mv.dx = tpe_pkg::mag33(ix);
            mv.dy = tpe_pkg::mag33(iy);
            mv.dz = tpe_pkg::mag33(iz);
            mv.pos_x = tpe_pkg::sat33(cx + ix);
            mv.pos_y = tpe_pkg::sat33(cy + iy);
            mv.pos_z = tpe_pkg::sat33(cz + iz);
        end else begin
            mv.dx = tpe_pkg::mag33(cx - ix);
            mv.dy = tpe_pkg::mag33(cy - iy);
            mv.pos_x = s_coord_x;
            mv.pos_y = s_coord_y;
            if (s_keep_z) begin
                mv.dz = '0;
                mv.pos_z = cur_z_reg;
            end else begin
                mv.dz = tpe_pkg::mag33(cz - iz);
                mv.pos_z = s_coord_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_z_reg <= tpe_pkg::START_Z;
        end else if (q_push) begin
            cur_x_reg <= mv.pos_x;
            cur_y_reg <= mv.pos_y;
            cur_z_reg <= mv.pos_z;
        end
    end

endmodule

### rtl/core/tpe_queue.sv
module tpe_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tpe_pkg::move_t     push_data,
    input  logic               pop,
    output tpe_pkg::move_t     pop_data,
    output logic               full,
    output logic               empty
);

    tpe_pkg::move_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/tpe_isqrt.sv
module tpe_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpe_pkg::RAD_W-1:0]     rad,
    output logic                          done,
    output logic [tpe_pkg::ROOT_W-1:0]    root
);

    logic [tpe_pkg::RAD_W-1:0]  rad_reg;
    logic [tpe_pkg::REM_W-1:0]  rem_reg, rem_sh, trial;
    logic [tpe_pkg::ROOT_W-1:0] root_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic                       fits;

    assign done = done_reg;
    assign root = root_reg;

    always_comb begin
        rem_sh = {rem_reg[tpe_pkg::REM_W-3:0], rad_reg[tpe_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[tpe_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[tpe_pkg::ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(tpe_pkg::ROOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/tpe_back.sv
module tpe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        extrusion_gain,
    input  logic               q_empty,
    input  tpe_pkg::move_t     q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_pos_x,
    output logic [31:0]        m_pos_y,
    output logic [31:0]        m_pos_z,
    output logic [47:0]        m_total_extrusion,
    output logic [15:0]        m_feed_rate,
    output logic               m_was_extruding
);

    tpe_pkg::back_state_t state_reg, state_next;
    tpe_pkg::move_t mv_reg;
    logic [1:0]  cnt_reg;
    logic [63:0] prod_reg;
    logic [tpe_pkg::RAD_W-1:0] sum_reg;
    logic [tpe_pkg::RAD_W-1:0] rad_in;
    logic [40:0] p_hi_reg;
    logic [55:0] p_lo_reg;
    logic [47:0] ext_reg;
    logic [48:0] ext_sum;
    logic [31:0] sel;
    logic        root_start, root_done, load_out;
    logic [tpe_pkg::ROOT_W-1:0] root;
    logic        m_valid_reg;
    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [47:0] total_reg;
    logic [15:0] feed_reg;
    logic        extr_reg;

    tpe_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .rad     (rad_in),
        .done    (root_done),
        .root    (root)
    );

    always_comb begin
        case (cnt_reg)
            2'd0:    sel = mv_reg.dx;
            2'd1:    sel = mv_reg.dy;
            default: sel = mv_reg.dz;
        endcase
        // last square is still in prod_reg when the root starts
        rad_in  = sum_reg + tpe_pkg::RAD_W'(prod_reg);
        ext_sum = {1'b0, ext_reg} + 49'(p_hi_reg) + 49'(p_lo_reg[55:24]);
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        root_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            tpe_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    state_next = q_data.extrude ? tpe_pkg::B_SQ : tpe_pkg::B_OUT;
                end
            end
            tpe_pkg::B_SQ: begin
                if (cnt_reg == 2'd3) begin
                    root_start = 1'b1;
                    state_next = tpe_pkg::B_ROOT;
                end
            end
            tpe_pkg::B_ROOT: begin
                if (root_done) begin
                    state_next = tpe_pkg::B_MUL;
                end
            end
            tpe_pkg::B_MUL: state_next = tpe_pkg::B_ACC;
            tpe_pkg::B_ACC: state_next = tpe_pkg::B_OUT;
            tpe_pkg::B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    state_next = tpe_pkg::B_IDLE;
                end
            end
            default: state_next = tpe_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mv_reg <= q_data;
        end
        if (state_reg == tpe_pkg::B_IDLE) begin
            cnt_reg <= '0;
        end else if (state_reg == tpe_pkg::B_SQ) begin
            cnt_reg  <= cnt_reg + 2'd1;
            prod_reg <= 64'(sel) * 64'(sel);
            if (cnt_reg == 2'd0) begin
                sum_reg <= '0;
            end else begin
                sum_reg <= sum_reg + tpe_pkg::RAD_W'(prod_reg);
            end
        end
        if (state_reg == tpe_pkg::B_MUL) begin
            p_hi_reg <= 41'(root[32:24]) * 41'(extrusion_gain);
            p_lo_reg <= 56'(root[23:0]) * 56'(extrusion_gain);
        end
        if (load_out) begin
            pos_x_reg <= mv_reg.pos_x;
            pos_y_reg <= mv_reg.pos_y;
            pos_z_reg <= mv_reg.pos_z;
            total_reg <= ext_reg;
            feed_reg  <= mv_reg.feed;
            extr_reg  <= mv_reg.extrude;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpe_pkg::B_IDLE;
            ext_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tpe_pkg::B_ACC) begin
                ext_reg <= ext_sum[48] ? tpe_pkg::EXT_MAX : ext_sum[47:0];
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pos_x           = pos_x_reg;
    assign m_pos_y           = pos_y_reg;
    assign m_pos_z           = pos_z_reg;
    assign m_total_extrusion = total_reg;
    assign m_feed_rate       = feed_reg;
    assign m_was_extruding   = extr_reg;

endmodule

### rtl/core/toolhead_position_extrusion_tracker.sv
// Tracks tool position and total extrusion for a stream of motion words. The front
// updates X/Y/Z in the accept cycle and queues up to two words; for an extruding word the back squares the
// per-axis distances (one 32x32 multiplier), takes a bit-serial square root
// (one result bit per cycle), scales by the gain and accumulates; a travel word skips
// these steps. The square root loop sets the rate of extruding words.
// Positions saturate to signed 32 bits, extrusion to 2^48-1.
module toolhead_position_extrusion_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_coord_x,
    input  logic [31:0] s_coord_y,
    input  logic [31:0] s_coord_z,
    input  logic        s_keep_z,
    input  logic        s_extrude,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pos_x,
    output logic [31:0] m_pos_y,
    output logic [31:0] m_pos_z,
    output logic [47:0] m_total_extrusion,
    output logic [15:0] m_feed_rate,
    output logic        m_was_extruding
);

    logic [31:0] gain_reg;
    logic [15:0] print_feed_reg, travel_feed_reg;
    logic        q_push, q_pop, q_full, q_empty;
    tpe_pkg::move_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= tpe_pkg::GAIN_RESET;
            print_feed_reg  <= tpe_pkg::PRINT_FEED_RESET;
            travel_feed_reg <= tpe_pkg::TRAVEL_FEED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tpe_pkg::REG_GAIN:        gain_reg        <= cfg_data;
                tpe_pkg::REG_PRINT_FEED:  print_feed_reg  <= cfg_data[15:0];
                tpe_pkg::REG_TRAVEL_FEED: travel_feed_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tpe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .s_keep_z    (s_keep_z),
        .s_extrude   (s_extrude),
        .print_feed  (print_feed_reg),
        .travel_feed (travel_feed_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    tpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    tpe_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .extrusion_gain    (gain_reg),
        .q_empty           (q_empty),
        .q_data            (q_out),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pos_x           (m_pos_x),
        .m_pos_y           (m_pos_y),
        .m_pos_z           (m_pos_z),
        .m_total_extrusion (m_total_extrusion),
        .m_feed_rate       (m_feed_rate),
        .m_was_extruding   (m_was_extruding)
    );

endmodule

### bench/tb_toolhead_position_extrusion_tracker.sv
`timescale 1ns / 1ps

module tb_toolhead_position_extrusion_tracker;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [31:0] s_coord_x = '0;
    logic [31:0] s_coord_y = '0;
    logic [31:0] s_coord_z = '0;
    logic        s_keep_z = 1'b0;
    logic        s_extrude = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pos_x;
    logic [31:0] m_pos_y;
    logic [31:0] m_pos_z;
    logic [47:0] m_total_extrusion;
    logic [15:0] m_feed_rate;
    logic        m_was_extruding;

    toolhead_position_extrusion_tracker dut (.*);

    always #10 aclk = ~aclk;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [47:0] ext;
        logic [15:0] feed;
        logic        extr;
    } pose_t;

    typedef struct packed {
        logic        rel;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        keep;
        logic        extr;
        logic        known;
        pose_t       want;
    } cmd_t;

    pose_t pose_q[$];

    logic [31:0] gain;
    logic [15:0] pfeed, tfeed;
    logic signed [31:0] tx, ty, tz;
    logic [47:0] ext_sum;

    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;

    function automatic logic [34:0] isqrt66(input logic [65:0] v);
        logic [34:0] r;
        logic [69:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (35'd1 << b);
            if (c * c <= {4'd0, v}) r = r | (35'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [33:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d[33] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic signed [31:0] satadd(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        if (s > 33'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
        if (s < -33'sh0_8000_0000) return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic pose_t track_move(input cmd_t c);
        logic [32:0] dx, dy, dz;
        logic [65:0] sumsq;
        logic [34:0] len;
        logic [67:0] inc;
        pose_t p;
        if (c.rel) begin
            dx = absdiff(c.x, 0);
            dy = absdiff(c.y, 0);
            dz = absdiff(c.z, 0);
            tx = satadd(tx, c.x);
            ty = satadd(ty, c.y);
            tz = satadd(tz, c.z);
        end else begin
            dx = absdiff(tx, c.x);
            dy = absdiff(ty, c.y);
            dz = c.keep ? 33'd0 : absdiff(tz, c.z);
            tx = c.x;
            ty = c.y;
            if (!c.keep) tz = c.z;
        end
        if (c.extr) begin
            sumsq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
            len = isqrt66(sumsq);
            inc = (68'(len) * 68'(gain)) >> 24;
            if (inc > 68'(48'hFFFF_FFFF_FFFF - ext_sum)) ext_sum = '1;
            else ext_sum = ext_sum + inc[47:0];
        end
        p.px = tx;
        p.py = ty;
        p.pz = tz;
        p.ext = ext_sum;
        p.feed = c.extr ? pfeed : tfeed;
        p.extr = c.extr;
        return p;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            tpe_pkg::REG_GAIN: gain = val;
            tpe_pkg::REG_PRINT_FEED: pfeed = val[15:0];
            tpe_pkg::REG_TRAVEL_FEED: tfeed = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_move(input cmd_t c);
        pose_t p;
        while (!no_idle && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= c.rel;
        s_coord_x <= c.x;
        s_coord_y <= c.y;
        s_coord_z <= c.z;
        s_keep_z <= c.keep;
        s_extrude <= c.extr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = track_move(c);
        if (c.known && p != c.want) begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: expected %h got %h", c.want, p);
        end
        pose_q = {pose_q, p};
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        pose_t got, w;
        if (aresetn && m_valid && m_ready) begin
            got = {m_pos_x, m_pos_y, m_pos_z, m_total_extrusion, m_feed_rate,
                   m_was_extruding};
            if (pose_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
            end else begin
                w = pose_q.pop_front();
                if (got !== w) begin
                    errors++;
                    if (errors <= 10)
                        $display("result mismatch: expected %h got %h", w, got);
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
        endcase
    endfunction

    function automatic cmd_t mk(input logic rel, input logic [31:0] x, y, z,
                                input logic keep, extr);
        cmd_t c;
        c = '0;
        c.rel = rel; c.x = x; c.y = y; c.z = z; c.keep = keep; c.extr = extr;
        return c;
    endfunction

    cmd_t dir_tab[$];

    initial begin
        cmd_t c;
        gain = tpe_pkg::GAIN_RESET;
        pfeed = tpe_pkg::PRINT_FEED_RESET;
        tfeed = tpe_pkg::TRAVEL_FEED_RESET;
        tx = 0; ty = 0; tz = tpe_pkg::START_Z; ext_sum = '0;

        // first row: travel to origin with Z kept, state straight after reset
        c = mk(1'b0, 0, 0, 0, 1'b1, 1'b0);
        c.known = 1'b1;
        c.want = {32'd0, 32'd0, tpe_pkg::START_Z, 48'd0, tpe_pkg::TRAVEL_FEED_RESET, 1'b0};
        dir_tab = {dir_tab, c};
        // 10 mm extruding move along X: len = 10<<16
        c = mk(1'b0, 32'h000A_0000, 0, 0, 1'b1, 1'b1);
        c.known = 1'b1;
        c.want = {32'h000A_0000, 32'd0, tpe_pkg::START_Z,
                  48'((64'h000A_0000 * 64'd558015) >> 24), tpe_pkg::PRINT_FEED_RESET,
                  1'b1};
        dir_tab = {dir_tab, c};
        dir_tab = {dir_tab, mk(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1)};
        dir_tab = {dir_tab, mk(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1)};
        dir_tab = {dir_tab, mk(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1)};
        dir_tab = {dir_tab, mk(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1)};
        dir_tab = {dir_tab, mk(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1)};
        dir_tab = {dir_tab, mk(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0)};
        dir_tab = {dir_tab, mk(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 1, 1)};
        dir_tab = {dir_tab, mk(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0)};
        dir_tab = {dir_tab, mk(1'b1, 0, 0, 0, 0, 1)};
        dir_tab = {dir_tab, mk(1'b1, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF, 1, 1)};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_move(dir_tab[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(tpe_pkg::REG_GAIN, 32'hFFFF_FFFF);
                    write_reg(tpe_pkg::REG_PRINT_FEED, 32'hFFFF);
                    write_reg(tpe_pkg::REG_TRAVEL_FEED, 32'h0);
                end
                1: begin
                    write_reg(tpe_pkg::REG_GAIN, 32'h0);
                    write_reg(tpe_pkg::REG_PRINT_FEED, 32'h0);
                    write_reg(tpe_pkg::REG_TRAVEL_FEED, 32'hFFFF);
                end
                2: write_reg(2'd3, $urandom);
                default: begin
                    write_reg(tpe_pkg::REG_GAIN, $urandom_range(32'h0400_0000));
                    write_reg(tpe_pkg::REG_PRINT_FEED, $urandom);
                    write_reg(tpe_pkg::REG_TRAVEL_FEED, $urandom);
                end
            endcase
            cfg_wr_en <= 1'b0;
            no_idle = (ph == 3);
            for (int n = 0; n < 225; n++) begin
                c = mk($urandom_range(1), rnd_coord(), rnd_coord(), rnd_coord(),
                       $urandom_range(1), $urandom_range(3) != 0);
                if (c.rel && $urandom_range(3) != 0) begin
                    c.x = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
                    c.y = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
                    c.z = 32'($signed($urandom_range(2 << 16)) - (1 << 16));
                end
                send_move(c);
            end
            no_idle = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### toolhead_position_extrusion_tracker.f
rtl/core/tpe_pkg.sv
rtl/core/tpe_front.sv
rtl/core/tpe_queue.sv
rtl/core/tpe_isqrt.sv
rtl/core/tpe_back.sv
rtl/core/toolhead_position_extrusion_tracker.sv
bench/tb_toolhead_position_extrusion_tracker.sv
